/* rtl/core/ttg_pkg.sv */
// Shared types and constants of the trapezoidal trajectory generator.
// Used by ttg_mul and trapezoidal_trajectory_generator_unit; no dependencies.
`default_nettype none

package ttg_pkg;

  // Default position width (signed Q24.16 degrees).
  localparam int POSITION_WIDTH_DEF = 40;

  // Register and field widths.
  localparam int MAXV_W     = 40;
  localparam int ACC_W      = 40;
  localparam int TS_W       = 24;
  localparam int VEL_W      = 41;
  localparam int VEL_MAG_W  = 40;
  localparam int CFG_W      = 40;
  localparam int CFG_IDX_W  = 2;

  // Reset values of the configuration registers.
  localparam logic [MAXV_W-1:0] MAXV_RST = 40'd23592960;
  localparam logic [ACC_W-1:0]  ACC_RST  = 40'd235929600;
  localparam logic [TS_W-1:0]   TS_RST   = 24'd839;

  // Snap band: 0.01 degree in Q16.
  localparam int SNAP_BAND = 655;

  // Digit-serial multiplier geometry.
  localparam int DIGIT_W      = 8;
  localparam int MUL_B_W      = 48;
  localparam int LONG_DIGITS  = MUL_B_W / DIGIT_W;
  localparam int SHORT_DIGITS = TS_W / DIGIT_W;
  localparam int CNT_W        = $clog2(LONG_DIGITS + 1);
  localparam int MUL_A_W_DEF  = 40;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_VELOCITY = 2'd0,
    CFG_ACCELERATION = 2'd1,
    CFG_TIME_STEP    = 2'd2
  } cfg_index_e;

  // Sequencer states.
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EVAL,
    ST_MUL_DV,
    ST_MUL_LHS,
    ST_MUL_RHS,
    ST_VEL,
    ST_STEP,
    ST_MUL_STEP,
    ST_POS,
    ST_DONE
  } state_e;

  // Control from the sequencer to the multiplier.
  typedef struct packed {
    logic start;
    logic short_op;
  } mul_ctrl_t;

endpackage

`default_nettype wire

/* rtl/core/ttg_mul.sv */
// Digit-serial unsigned multiplier shared by all products of the generator.
// Depends on ttg_pkg for the digit geometry and the control struct.
`default_nettype none

module ttg_mul #(
  parameter int A_W = ttg_pkg::MUL_A_W_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire ttg_pkg::mul_ctrl_t               ctrl_i,
  input  wire logic [A_W-1:0]                   a_i,
  input  wire logic [ttg_pkg::MUL_B_W-1:0]      b_i,
  output logic                                  done_o,
  output logic [A_W+ttg_pkg::MUL_B_W-1:0]       prod_o
);
  import ttg_pkg::*;

  localparam int P_W = A_W + MUL_B_W;

  logic [A_W-1:0]         a_q, a_d;
  logic [MUL_B_W-1:0]     b_q, b_d;
  logic [P_W-1:0]         acc_q, acc_d;
  logic [CNT_W-1:0]       cnt_q, cnt_d;
  logic                   done_q, done_d;
  logic [A_W+DIGIT_W-1:0] part;

  // One digit of b, taken from the top, times the whole of a.
  assign part = a_q * b_q[MUL_B_W-1 -: DIGIT_W];

  // Start loads the operands; every busy cycle folds in one more digit.
  always_comb begin
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (ctrl_i.start) begin
      a_d   = a_i;
      b_d   = b_i;
      acc_d = '0;
      cnt_d = ctrl_i.short_op ? CNT_W'(SHORT_DIGITS) : CNT_W'(LONG_DIGITS);
    end else if (cnt_q != '0) begin
      acc_d  = (acc_q << DIGIT_W) + P_W'(part);
      b_d    = b_q << DIGIT_W;
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q   <= a_d;
    b_q   <= b_d;
    acc_q <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

`default_nettype wire

/* rtl/core/trapezoidal_trajectory_generator_unit.sv */
// Trapezoidal trajectory generator: sequencer, profile state and stream ports.
// Depends on ttg_pkg and instantiates the shared multiplier ttg_mul.
//
// Each input item carries a target and a measured position and yields one
// position reference item. An item that lands within the snap band of the target
// (or restarts there) goes from evaluation straight to the output hand-over. A
// moving tick runs all four products (velocity increment, the two sides of the
// braking test, and the position step) one after another on a single
// 8-bit-per-cycle multiplier, 3 digits for products with the time step and 6 for
// the others. Input is taken only while the sequencer is idle; a finished
// result sits in the output register, so the next item may be accepted before
// it is taken.
`default_nettype none

module trapezoidal_trajectory_generator_unit #(
  parameter int POSITION_WIDTH = ttg_pkg::POSITION_WIDTH_DEF
) (
  input  wire logic                                       clk_i,
  input  wire logic                                       rst_ni,
  // Configuration write port.
  input  wire logic                                       cfg_we_i,
  input  wire logic [ttg_pkg::CFG_IDX_W-1:0]              cfg_idx_i,
  input  wire logic [ttg_pkg::CFG_W-1:0]                  cfg_data_i,
  // Input items: target_position, then current_position, zero padded to bytes.
  input  wire logic                                       s_axis_tvalid,
  output logic                                            s_axis_tready,
  input  wire logic [((2*POSITION_WIDTH+7)/8)*8-1:0]      s_axis_tdata,
  // Result items: reference_position, zero padded to bytes.
  output logic                                            m_axis_tvalid,
  input  wire logic                                       m_axis_tready,
  output logic [((POSITION_WIDTH+7)/8)*8-1:0]             m_axis_tdata
);
  import ttg_pkg::*;

  localparam int PW    = POSITION_WIDTH;
  localparam int OUT_W = ((PW + 7) / 8) * 8;
  localparam int AW    = (PW > VEL_MAG_W) ? PW : VEL_MAG_W;
  localparam int PRW   = AW + MUL_B_W;
  localparam int EW    = AW + 2;

  // Configuration registers.
  logic [MAXV_W-1:0] maxv_q;
  logic [ACC_W-1:0]  acc_q;
  logic [TS_W-1:0]   ts_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      maxv_q <= MAXV_RST;
      acc_q  <= ACC_RST;
      ts_q   <= TS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_MAX_VELOCITY: maxv_q <= cfg_data_i[MAXV_W-1:0];
        CFG_ACCELERATION: acc_q  <= cfg_data_i[ACC_W-1:0];
        CFG_TIME_STEP:    ts_q   <= cfg_data_i[TS_W-1:0];
        default: ;
      endcase
    end
  end

  // Sequencer and profile state.
  state_e            state_q, state_d;
  logic [PW-1:0]     pos_q, pos_d;
  logic [VEL_W-1:0]  vel_q, vel_d;
  logic [PW-1:0]     last_q, last_d;
  logic              out_valid_q, out_valid_d;
  logic [OUT_W-1:0]  out_data_q, out_data_d;

  // Per-item working registers.
  logic [PW-1:0]     tgt_q, tgt_d;
  logic [PW-1:0]     cur_q, cur_d;
  logic [PW-1:0]     err_q, err_d;
  logic              dir_pos_q, dir_pos_d;
  logic [ACC_W-1:0]  dv_q, dv_d;
  logic [PRW-1:0]    lhs_q, lhs_d;
  logic              decel_q, decel_d;

  // Shared multiplier.
  mul_ctrl_t         mul_ctrl;
  logic [AW-1:0]     mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic              mul_done;
  logic [PRW-1:0]    mul_prod;

  ttg_mul #(
    .A_W (AW)
  ) u_mul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (mul_ctrl),
    .a_i    (mul_a),
    .b_i    (mul_b),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Restart and distance to target.
  logic              tgt_changed;
  logic [PW-1:0]     pos_eff;
  logic [PW:0]       diff;
  logic [PW:0]       diff_neg;
  logic              eval_dir_pos;
  logic [PW-1:0]     eval_err;
  logic              eval_snap;

  always_comb begin
    tgt_changed  = (tgt_q != last_q);
    pos_eff      = tgt_changed ? cur_q : pos_q;
    diff         = {tgt_q[PW-1], tgt_q} - {pos_eff[PW-1], pos_eff};
    diff_neg     = -diff;
    eval_dir_pos = ~diff[PW];
    eval_err     = eval_dir_pos ? diff[PW-1:0] : diff_neg[PW-1:0];
    eval_snap    = (eval_err <= PW'(SNAP_BAND));
  end

  // Negation of a velocity, used for the limit in the negative direction.
  function automatic logic [VEL_W-1:0] vel_abs_neg(input logic [VEL_W-1:0] v);
    return -v;
  endfunction

  // Velocity magnitude and the velocity update.
  logic [VEL_W-1:0]     vel_abs;
  logic [VEL_MAG_W-1:0] vmag;
  logic signed [VEL_W:0] vel_x, dv_x, vel_dec, vel_acc, acc_abs, maxv_x;
  logic [VEL_W-1:0]     vel_new;

  always_comb begin
    vel_abs = vel_q[VEL_W-1] ? -vel_q : vel_q;
    vmag    = vel_abs[VEL_MAG_W-1:0];
    vel_x   = {vel_q[VEL_W-1], vel_q};
    dv_x    = {{(VEL_W + 1 - ACC_W){1'b0}}, dv_q};
    maxv_x  = {{(VEL_W + 1 - MAXV_W){1'b0}}, maxv_q};
    vel_dec = dir_pos_q ? (vel_x - dv_x) : (vel_x + dv_x);
    vel_acc = dir_pos_q ? (vel_x + dv_x) : (vel_x - dv_x);
    acc_abs = vel_acc[VEL_W] ? -vel_acc : vel_acc;
    vel_new = vel_q;
    if (decel_q) begin
      // Braking never reverses the direction of travel.
      if (dir_pos_q ? (vel_dec <= 0) : (vel_dec >= 0)) begin
        vel_new = '0;
      end else begin
        vel_new = vel_dec[VEL_W-1:0];
      end
    end else if (vmag < maxv_q) begin
      if (acc_abs > maxv_x) begin
        vel_new = dir_pos_q ? maxv_x[VEL_W-1:0] : vel_abs_neg(maxv_x[VEL_W-1:0]);
      end else begin
        vel_new = vel_acc[VEL_W-1:0];
      end
    end
  end

  // Position step with saturation and the overshoot clamp.
  logic [VEL_MAG_W-1:0]  smag;
  logic signed [EW-1:0]  pos_x, smag_x, pos_sum, pmax_x, pmin_x;
  logic [PW-1:0]         pos_step;
  logic                  vel_pos, vel_neg, overshoot;

  always_comb begin
    smag     = mul_prod[TS_W +: VEL_MAG_W];
    pos_x    = {{(EW - PW){pos_q[PW-1]}}, pos_q};
    smag_x   = {{(EW - VEL_MAG_W){1'b0}}, smag};
    pmax_x   = {{(EW - PW + 1){1'b0}}, {(PW - 1){1'b1}}};
    pmin_x   = ~pmax_x;
    vel_pos  = ~vel_q[VEL_W-1] && (vel_q != '0);
    vel_neg  = vel_q[VEL_W-1];
    pos_sum  = pos_x;
    if (vel_pos) begin
      pos_sum = pos_x + smag_x;
    end else if (vel_neg) begin
      pos_sum = pos_x - smag_x;
    end
    if (pos_sum > pmax_x) begin
      pos_step = pmax_x[PW-1:0];
    end else if (pos_sum < pmin_x) begin
      pos_step = pmin_x[PW-1:0];
    end else begin
      pos_step = pos_sum[PW-1:0];
    end
    overshoot = dir_pos_q ? ($signed(pos_step) >= $signed(tgt_q))
                          : ($signed(pos_step) <= $signed(tgt_q));
  end

  // Next state, state updates and multiplier requests.
  always_comb begin
    state_d     = state_q;
    pos_d       = pos_q;
    vel_d       = vel_q;
    last_d      = last_q;
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    tgt_d       = tgt_q;
    cur_d       = cur_q;
    err_d       = err_q;
    dir_pos_d   = dir_pos_q;
    dv_d        = dv_q;
    lhs_d       = lhs_q;
    decel_d     = decel_q;
    mul_ctrl    = '{start: 1'b0, short_op: 1'b0};
    mul_a       = AW'(acc_q);
    mul_b       = {ts_q, {(MUL_B_W - TS_W){1'b0}}};
    s_axis_tready = (state_q == ST_IDLE);

    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          tgt_d   = s_axis_tdata[PW-1:0];
          cur_d   = s_axis_tdata[2*PW-1:PW];
          state_d = ST_EVAL;
        end
      end
      ST_EVAL: begin
        last_d    = tgt_q;
        dir_pos_d = eval_dir_pos;
        err_d     = eval_err;
        if (eval_snap) begin
          pos_d   = tgt_q;
          vel_d   = '0;
          state_d = ST_DONE;
        end else begin
          pos_d    = pos_eff;
          vel_d    = tgt_changed ? '0 : vel_q;
          // Velocity increment: acceleration times time step.
          mul_ctrl = '{start: 1'b1, short_op: 1'b1};
          mul_a    = AW'(acc_q);
          mul_b    = {ts_q, {(MUL_B_W - TS_W){1'b0}}};
          state_d  = ST_MUL_DV;
        end
      end
      ST_MUL_DV: begin
        if (mul_done) begin
          dv_d     = mul_prod[TS_W +: ACC_W];
          // Left side of the braking test: distance times twice the acceleration.
          mul_ctrl = '{start: 1'b1, short_op: 1'b0};
          mul_a    = AW'(err_q);
          mul_b    = MUL_B_W'({acc_q, 1'b0});
          state_d  = ST_MUL_LHS;
        end
      end
      ST_MUL_LHS: begin
        if (mul_done) begin
          lhs_d    = mul_prod;
          // Right side: velocity squared.
          mul_ctrl = '{start: 1'b1, short_op: 1'b0};
          mul_a    = AW'(vmag);
          mul_b    = MUL_B_W'(vmag);
          state_d  = ST_MUL_RHS;
        end
      end
      ST_MUL_RHS: begin
        if (mul_done) begin
          decel_d = (lhs_q <= mul_prod);
          state_d = ST_VEL;
        end
      end
      ST_VEL: begin
        vel_d   = vel_new;
        state_d = ST_STEP;
      end
      ST_STEP: begin
        // Distance covered this tick: speed times time step.
        mul_ctrl = '{start: 1'b1, short_op: 1'b1};
        mul_a    = AW'(vmag);
        mul_b    = {ts_q, {(MUL_B_W - TS_W){1'b0}}};
        state_d  = ST_MUL_STEP;
      end
      ST_MUL_STEP: begin
        if (mul_done) begin
          state_d = ST_POS;
        end
      end
      ST_POS: begin
        if (overshoot) begin
          pos_d = tgt_q;
          vel_d = '0;
        end else begin
          pos_d = pos_step;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        // Hand the result to the output register once it is free.
        if (!out_valid_q || m_axis_tready) begin
          out_data_d  = OUT_W'(pos_q);
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      pos_q       <= '0;
      vel_q       <= '0;
      last_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      pos_q       <= pos_d;
      vel_q       <= vel_d;
      last_q      <= last_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
    tgt_q      <= tgt_d;
    cur_q      <= cur_d;
    err_q      <= err_d;
    dir_pos_q  <= dir_pos_d;
    dv_q       <= dv_d;
    lhs_q      <= lhs_d;
    decel_q    <= decel_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

`default_nettype wire

/* bench/trapezoidal_trajectory_generator_unit_tb.sv */
// Self-checking testbench for trapezoidal_trajectory_generator_unit: profile moves,
// snapping and register settings, with a bit-true profile predictor and random idling.
// Depends on ttg_pkg and the RTL of the block only.
`timescale 1ns / 1ps

module trapezoidal_trajectory_generator_unit_tb;
  import ttg_pkg::*;

  localparam int POS_W = POSITION_WIDTH_DEF;
  localparam int IN_W = ((2 * POS_W + 7) / 8) * 8;
  localparam int OUT_W = ((POS_W + 7) / 8) * 8;
  localparam int ITEM_GOAL = 1450;
  localparam int SETTLE_CYCLES = 8;
  localparam int TAIL_CYCLES = 64;
  localparam int CYCLE_LIMIT = 600000;
  localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

  localparam longint POS_HI = (64'sd1 <<< (POS_W - 1)) - 1;
  localparam longint POS_LO = -POS_HI - 1;
  localparam longint VEL_LIM = (64'sd1 <<< (VEL_W - 1)) - 1;
  localparam longint SPAN_CAP = 64'sd1 <<< 37;
  localparam logic [MAXV_W-1:0] MAXV_TOP = '1;
  localparam logic [ACC_W-1:0] ACC_TOP = '1;
  localparam logic [TS_W-1:0] TS_TOP = '1;

  typedef enum logic [1:0] {ACT_ITEM, ACT_CFG, ACT_DRAIN} stim_kind_e;

  typedef struct {
    stim_kind_e           kind;
    logic [POS_W-1:0]     target;
    logic [POS_W-1:0]     measured;
    logic [CFG_IDX_W-1:0] reg_idx;
    logic [CFG_W-1:0]     reg_value;
  } stim_action_t;

  // Block ports.
  logic                 clk_i = 1'b0;
  logic                 rst_ni = 1'b0;
  logic                 cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [CFG_W-1:0]     cfg_data_i = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  // Fields from bit 0 up: target_position, current_position.
  logic [IN_W-1:0]      s_axis_tdata = '0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // Fields from bit 0 up: reference_position.
  logic [OUT_W-1:0]     m_axis_tdata;

  // Stimulus and scoreboard.
  stim_action_t         pending_actions[$];
  logic [POS_W-1:0]     expected_refs[$];
  int                   queued_items = 0;
  logic [POS_W-1:0]     gen_last_target = '0;
  int                   fail_count = 0;
  int                   outstanding = 0;
  int                   cycle_count = 0;

  // Driver and receiver state.
  int                   gap_left = 0;
  int                   burst_left = 1;
  int                   quiet_cycles = 0;
  int                   stall_mode = 0;
  int                   mode_left = 0;
  int                   pattern_cnt = 0;

  // Predictor copies of the registers and the profile state.
  logic [MAXV_W-1:0]       sh_maxv = MAXV_RST;
  logic [ACC_W-1:0]        sh_acc = ACC_RST;
  logic [TS_W-1:0]         sh_ts = TS_RST;
  logic signed [POS_W-1:0] prof_pos = '0;
  logic signed [VEL_W-1:0] prof_vel = '0;
  logic signed [POS_W-1:0] last_target = '0;

  trapezoidal_trajectory_generator_unit #(
    .POSITION_WIDTH(POS_W)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic logic [63:0] abs_mag(input longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  function automatic logic [POS_W-1:0] rand_pos();
    return POS_W'({$urandom(), $urandom()});
  endfunction

  // One profile tick: restart on a new target, snap, brake, accelerate or cruise,
  // then step the position and clamp on overshoot. Returns the reference position.
  function automatic logic [POS_W-1:0] advance_profile(input logic signed [POS_W-1:0] tgt,
                                                       input logic signed [POS_W-1:0] meas);
    longint       pos, vel, dv, goal;
    logic [63:0]  err_mag, vmag, step_mag;
    logic [127:0] brake_lhs, brake_rhs;
    bit           toward_pos;
    if (tgt != last_target) begin
      prof_pos = meas;
      prof_vel = '0;
      last_target = tgt;
    end
    goal = tgt;
    pos = prof_pos;
    vel = prof_vel;
    toward_pos = (goal >= pos);
    err_mag = toward_pos ? 64'(goal - pos) : 64'(pos - goal);
    if (err_mag <= 64'(SNAP_BAND)) begin
      prof_pos = tgt;
      prof_vel = '0;
      return tgt;
    end
    dv = longint'((64'(sh_acc) * 64'(sh_ts)) >> 24);
    vmag = abs_mag(vel);
    brake_lhs = 128'(err_mag) * 128'({sh_acc, 1'b0});
    brake_rhs = 128'(vmag) * 128'(vmag);
    if (brake_lhs <= brake_rhs) begin
      // Braking never reverses the direction of travel.
      vel = toward_pos ? vel - dv : vel + dv;
      if (toward_pos ? (vel <= 0) : (vel >= 0)) vel = 0;
    end else if (vmag < 64'(sh_maxv)) begin
      vel = toward_pos ? vel + dv : vel - dv;
      if (abs_mag(vel) > 64'(sh_maxv)) vel = toward_pos ? longint'(sh_maxv) : -longint'(sh_maxv);
    end
    if (vel > VEL_LIM) vel = VEL_LIM;
    if (vel < -VEL_LIM - 1) vel = -VEL_LIM - 1;
    // Step in the direction of the velocity, saturating at the position range.
    step_mag = (abs_mag(vel) * 64'(sh_ts)) >> 24;
    if (vel > 0) begin
      pos = (pos > POS_HI - longint'(step_mag)) ? POS_HI : pos + longint'(step_mag);
    end else if (vel < 0) begin
      pos = (pos < POS_LO + longint'(step_mag)) ? POS_LO : pos - longint'(step_mag);
    end
    if ((toward_pos && pos >= goal) || (!toward_pos && pos <= goal)) begin
      pos = goal;
      vel = 0;
    end
    prof_pos = pos[POS_W-1:0];
    prof_vel = vel[VEL_W-1:0];
    return prof_pos;
  endfunction

  task automatic note_mismatch(input string what, input logic [POS_W-1:0] want,
                               input logic [POS_W-1:0] got);
    fail_count++;
    if (fail_count <= 10) begin
      $display("%0t ns: %s: expected %0d, actual %0d", $time, what, $signed(want), $signed(got));
    end
  endtask

  task automatic queue_item(input logic [POS_W-1:0] tgt, input logic [POS_W-1:0] meas);
    stim_action_t a;
    a = '{ACT_ITEM, tgt, meas, '0, '0};
    pending_actions.push_back(a);
    gen_last_target = tgt;
    queued_items++;
  endtask

  task automatic queue_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    stim_action_t a;
    a = '{ACT_CFG, '0, '0, idx, value};
    pending_actions.push_back(a);
  endtask

  task automatic queue_drain();
    stim_action_t a;
    a = '{ACT_DRAIN, '0, '0, '0, '0};
    pending_actions.push_back(a);
  endtask

  // Stimulus: directed cases, then random phases of profile moves, then the wrap-up.
  initial begin
    logic [TS_W-1:0]   ts;
    logic [ACC_W-1:0]  acc;
    logic [MAXV_W-1:0] vmax;
    logic [63:0]       unit, dv, step_unit, vmax_wide;
    logic [127:0]      acc_wide;
    longint            base, span, tgt;
    int                moves, ticks, pick;

    // Snap at the reset target, snap band edge, smallest move, full-range moves.
    queue_item('0, POS_W'(POS_HI));
    queue_item(POS_W'(SNAP_BAND), '0);
    queue_item(POS_W'(-(SNAP_BAND + 1)), '0);
    queue_item(POS_W'(POS_LO), POS_W'(POS_HI));
    queue_item(POS_W'(POS_HI), POS_W'(POS_LO));
    queue_item(POS_W'(POS_HI), POS_W'(POS_LO));

    // Largest settings: huge steps, and saturation of the position sum.
    queue_cfg(CFG_MAX_VELOCITY, CFG_W'(MAXV_TOP));
    queue_cfg(CFG_ACCELERATION, CFG_W'(ACC_TOP));
    queue_cfg(CFG_TIME_STEP, CFG_W'(TS_TOP));
    queue_cfg(CFG_UNMAPPED, '1);
    queue_item(POS_W'(POS_LO), POS_W'(POS_HI));
    queue_item(POS_W'(POS_LO), POS_W'(POS_HI));
    queue_item(POS_W'(POS_HI), POS_W'(POS_HI - 1000));
    queue_item(POS_W'(POS_LO), POS_W'(POS_LO + 1000));

    // Smallest settings: the profile cannot get moving.
    queue_cfg(CFG_MAX_VELOCITY, CFG_W'(1));
    queue_cfg(CFG_ACCELERATION, CFG_W'(1));
    queue_cfg(CFG_TIME_STEP, CFG_W'(1));
    queue_item(POS_W'(100000), '0);
    queue_item(POS_W'(100000), rand_pos());

    // Speed up, then lower the limit below the present speed: the profile cruises on.
    queue_cfg(CFG_MAX_VELOCITY, CFG_W'(MAXV_TOP));
    queue_cfg(CFG_ACCELERATION, CFG_W'(64'd1 << 30));
    queue_cfg(CFG_TIME_STEP, CFG_W'(64'd1 << 23));
    repeat (4) queue_item(POS_W'(64'sd1 <<< 38), POS_W'(-(64'sd1 <<< 38)));
    queue_cfg(CFG_MAX_VELOCITY, CFG_W'(64'd1 << 20));
    repeat (3) queue_item(POS_W'(64'sd1 <<< 38), rand_pos());

    // Random phases, each with its own register setting and several moves.
    while (queued_items < ITEM_GOAL) begin
      pick = $urandom_range(0, 5);
      if (pick == 0) ts = TS_TOP;
      else if (pick == 1) ts = TS_W'($urandom_range(1, 255));
      else ts = TS_W'($urandom_range(1 << 18, 32'(TS_TOP)));
      // Aim at a chosen distance per tick squared, so moves last tens of ticks.
      unit = 64'd1 << $urandom_range(10, 30);
      acc_wide = (128'(unit) << 48) / (128'(ts) * 128'(ts));
      if (acc_wide > 128'(ACC_TOP)) acc = ACC_TOP;
      else if (acc_wide == 0) acc = 1;
      else acc = acc_wide[ACC_W-1:0];
      dv = (64'(acc) * 64'(ts)) >> 24;
      pick = $urandom_range(0, 4);
      if (pick == 0) vmax_wide = 64'(MAXV_TOP);
      else if (pick == 1) vmax_wide = 64'($urandom_range(1, 1000));
      else vmax_wide = dv * 64'($urandom_range(1, 24));
      if (vmax_wide > 64'(MAXV_TOP)) vmax = MAXV_TOP;
      else if (vmax_wide == 0) vmax = 1;
      else vmax = vmax_wide[MAXV_W-1:0];
      if ($urandom_range(0, 1)) begin
        queue_cfg(CFG_TIME_STEP, CFG_W'(ts));
        queue_cfg(CFG_MAX_VELOCITY, CFG_W'(vmax));
        queue_cfg(CFG_ACCELERATION, CFG_W'(acc));
      end else begin
        queue_cfg(CFG_ACCELERATION, CFG_W'(acc));
        queue_cfg(CFG_TIME_STEP, CFG_W'(ts));
        queue_cfg(CFG_MAX_VELOCITY, CFG_W'(vmax));
      end
      if ($urandom_range(0, 5) == 0) queue_cfg(CFG_UNMAPPED, CFG_W'({$urandom(), $urandom()}));

      step_unit = (dv * 64'(ts)) >> 24;
      if (step_unit > 64'(SPAN_CAP)) step_unit = 64'(SPAN_CAP);

      // Often keep the old target, so the profile carries on under the new setting.
      if ($urandom_range(0, 1)) begin
        repeat ($urandom_range(2, 10)) queue_item(gen_last_target, rand_pos());
      end

      moves = $urandom_range(3, 8);
      for (int m = 0; m < moves && queued_items < ITEM_GOAL; m++) begin
        if ($urandom_range(0, 19) == 0) begin
          queue_item(rand_pos(), rand_pos());
        end else begin
          ticks = $urandom_range(4, 48);
          if (step_unit == 0) span = longint'($urandom_range(SNAP_BAND + 1, 1 << 20));
          else span = longint'(step_unit) * longint'($urandom_range(1, ticks * ticks / 3));
          if (span > SPAN_CAP) span = SPAN_CAP;
          base = longint'($signed(rand_pos()) >>> 1);
          tgt = $urandom_range(0, 1) ? base + span : base - span;
          queue_item(POS_W'(tgt), POS_W'(base));
          repeat (ticks - 1) queue_item(POS_W'(tgt), rand_pos());
        end
        if ($urandom_range(0, 9) == 0) queue_drain();
      end
    end

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    while (pending_actions.size() != 0 || s_axis_tvalid || expected_refs.size() != 0) begin
      @(negedge clk_i);
    end
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (fail_count == 0 && expected_refs.size() == 0) begin
      $display("** trapezoidal_trajectory_generator_unit: PASSED **");
    end else begin
      $display("** trapezoidal_trajectory_generator_unit: FAILED **");
    end
    $finish;
  end

  // Driver: items go out in bursts; register writes and pauses wait until the
  // block has delivered every expected result and stayed quiet for a while.
  always @(posedge clk_i) begin
    logic         valid_next;
    logic         we_next;
    stim_action_t head;
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
      cfg_we_i <= 1'b0;
      gap_left = 0;
      burst_left = 1;
      quiet_cycles = 0;
    end else begin
      valid_next = s_axis_tvalid && !s_axis_tready;
      we_next = 1'b0;
      if (s_axis_tvalid || outstanding != 0) quiet_cycles = 0;
      else quiet_cycles++;
      if (!valid_next) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_actions.size() != 0) begin
          head = pending_actions[0];
          case (head.kind)
            ACT_ITEM: begin
              s_axis_tdata <= IN_W'({head.measured, head.target});
              valid_next = 1'b1;
              void'(pending_actions.pop_front());
              burst_left--;
              if (burst_left == 0) begin
                burst_left = $urandom_range(1, 16);
                gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
              end
            end
            ACT_CFG: begin
              if (quiet_cycles >= SETTLE_CYCLES) begin
                we_next = 1'b1;
                cfg_idx_i <= head.reg_idx;
                cfg_data_i <= head.reg_value;
                void'(pending_actions.pop_front());
              end
            end
            default: begin
              if (quiet_cycles >= SETTLE_CYCLES) void'(pending_actions.pop_front());
            end
          endcase
        end
      end
      s_axis_tvalid <= valid_next;
      cfg_we_i <= we_next;
    end
  end

  // Receiver: switches between always ready, random stalls and a fixed pattern.
  always @(posedge clk_i) begin
    logic ready;
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
    end else begin
      if (mode_left == 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(40, 400);
      end else begin
        mode_left--;
      end
      pattern_cnt++;
      case (stall_mode)
        0: ready = 1'b1;
        1: ready = 1'($urandom_range(0, 1));
        2: ready = (pattern_cnt % 4) == 0;
        default: ready = $urandom_range(0, 4) != 0;
      endcase
      m_axis_tready <= ready;
    end
  end

  // Monitor: mirrors register writes, predicts each accepted item and checks results.
  always @(posedge clk_i) begin
    logic [POS_W-1:0] want;
    if (!rst_ni) begin
      sh_maxv = MAXV_RST;
      sh_acc = ACC_RST;
      sh_ts = TS_RST;
      prof_pos = '0;
      prof_vel = '0;
      last_target = '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CFG_MAX_VELOCITY: sh_maxv = cfg_data_i[MAXV_W-1:0];
          CFG_ACCELERATION: sh_acc = cfg_data_i[ACC_W-1:0];
          CFG_TIME_STEP: sh_ts = cfg_data_i[TS_W-1:0];
          default: ;
        endcase
      end
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_refs.size() == 0) begin
          note_mismatch("unexpected reference_position", 'x, m_axis_tdata[POS_W-1:0]);
        end else begin
          want = expected_refs.pop_front();
          if (m_axis_tdata[POS_W-1:0] !== want) begin
            note_mismatch("reference_position", want, m_axis_tdata[POS_W-1:0]);
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        expected_refs.push_back(advance_profile(s_axis_tdata[POS_W-1:0],
                                                s_axis_tdata[2*POS_W-1:POS_W]));
      end
    end
    outstanding <= expected_refs.size();
  end

  // Watchdog on the whole run.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** trapezoidal_trajectory_generator_unit: FAILED **");
      $finish;
    end
  end

endmodule
